@@ sv/ftg_pkg.sv @@
// shared constants, types and arithmetic helpers for the foot swing trajectory core
package ftg_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int TERRAIN_FRAC  = 14;
    localparam int ATAN_COUNT    = 24;
    localparam int CORDIC_LAT    = CORDIC_STAGES + 2;

    // cordic datapath, trig result, angle accumulator
    localparam int CW = FRAC_BITS + 4;
    localparam int TW = FRAC_BITS + 3;
    localparam int ZW = 34;
    // offset, derivative and velocity widths
    localparam int PW = 20;
    localparam int DW = 44 - FRAC_BITS;
    localparam int VW = 54 - FRAC_BITS;
    localparam int WW = 24;
    localparam int EPW = PW + 16;
    localparam int EVW = VW + 16;
    localparam int PH_SH = 31 - 2 * FRAC_BITS;

    localparam longint GAIN_Q30 = 652032874;
    localparam longint PI_Q29   = 1686629713;
    localparam longint X_INIT   =
        (GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

    localparam logic [31:0] ATAN_TAB [ATAN_COUNT] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [2:0] {
        REG_STEP_LENGTH   = 3'd0,
        REG_STEP_HEIGHT   = 3'd1,
        REG_SWING_RATE    = 3'd2,
        REG_HEADING_ANGLE = 3'd3,
        REG_HEADING_SPEED = 3'd4,
        REG_TERRAIN_ROW0  = 3'd5,
        REG_TERRAIN_ROW1  = 3'd6,
        REG_TERRAIN_ROW2  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [17:0]        step_length;
        logic [17:0]        step_height;
        logic [19:0]        swing_rate;
        logic signed [15:0] heading_angle;
        logic signed [31:0] heading_speed;
        logic [47:0]        terrain_row0;
        logic [47:0]        terrain_row1;
        logic [47:0]        terrain_row2;
        logic [DW-1:0]      len_w;
        logic [DW-1:0]      hgt_w;
    } cfg_t;

    // round to nearest, ties toward plus infinity
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
        rnd = (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic signed [15:0] tentry(input logic [47:0] row, input int col);
        tentry = row[16 * col +: 16];
    endfunction

endpackage

@@ sv/foot_swing_trajectory_generator_core.sv @@
// an accepted word passes the phase product register, the cordic and five rotation
// stages to its result word; throughput: one word per cycle unless the output stalls.
// the whole pipeline holds while the output word is stalled.
// reset clears all valid bits and every configuration register to zero;
// a register write reaches the derived rate products via the rate register, then the product registers.
module foot_swing_trajectory_generator_core
    import ftg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic [19:0]        sample_time,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] foot_x,
    output logic signed [31:0] foot_y,
    output logic signed [31:0] foot_z,
    output logic signed [31:0] speed_x,
    output logic signed [31:0] speed_y,
    output logic signed [31:0] speed_z
);

    cfg_t                 cfg;
    logic                 en;
    logic [39:0]          ph_reg;
    logic                 vld_p_reg;
    logic signed [31:0]   st_p_reg [0:2];
    logic [71:0]          ph_wide;
    logic [31:0]          ang;
    logic                 vld_line_reg [0:CORDIC_LAT-1];
    logic signed [31:0]   st_line_reg  [0:CORDIC_LAT-1][0:2];
    logic signed [TW-1:0] cp, sp, ch, sh;

    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;

    ftg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_p_reg <= 1'b0;
        else if (en)
            vld_p_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg      <= 40'(cfg.swing_rate) * 40'(sample_time);
            st_p_reg[0] <= start_x;
            st_p_reg[1] <= start_y;
            st_p_reg[2] <= start_z;
        end
    end

    // phase as a binary angle, one turn is 2^32
    assign ph_wide = 72'(ph_reg);
    if (PH_SH >= 0)
    begin : g_shl
        assign ang = 32'(ph_wide << PH_SH);
    end
    else
    begin : g_shr
        assign ang = 32'(ph_wide >> (-PH_SH));
    end

    ftg_cordic u_phase (
        .clk     (clk),
        .en      (en),
        .angle   (ang),
        .cos_val (cp),
        .sin_val (sp)
    );

    ftg_cordic u_heading (
        .clk     (clk),
        .en      (en),
        .angle   ({cfg.heading_angle, 16'b0}),
        .cos_val (ch),
        .sin_val (sh)
    );

    // start position and valid ride alongside the cordic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CORDIC_LAT; k++)
                vld_line_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_line_reg[0] <= vld_p_reg;
            for (int k = 1; k < CORDIC_LAT; k++)
                vld_line_reg[k] <= vld_line_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_line_reg[0] <= st_p_reg;
            for (int k = 1; k < CORDIC_LAT; k++)
                st_line_reg[k] <= st_line_reg[k-1];
        end
    end

    ftg_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .valid_in  (vld_line_reg[CORDIC_LAT-1]),
        .cp        (cp),
        .sp        (sp),
        .ch        (ch),
        .sh        (sh),
        .st_x      (st_line_reg[CORDIC_LAT-1][0]),
        .st_y      (st_line_reg[CORDIC_LAT-1][1]),
        .st_z      (st_line_reg[CORDIC_LAT-1][2]),
        .valid_out (result_valid),
        .foot_x    (foot_x),
        .foot_y    (foot_y),
        .foot_z    (foot_z),
        .speed_x   (speed_x),
        .speed_y   (speed_y),
        .speed_z   (speed_z)
    );

endmodule

@@ sv/ftg_cfg.sv @@
// configuration register file and config-derived angular rate products
module ftg_cfg
    import ftg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output cfg_t        cfg
);

    localparam int LPW = WW + 18;

    logic [17:0]        step_length_reg;
    logic [17:0]        step_height_reg;
    logic [19:0]        swing_rate_reg;
    logic signed [15:0] heading_angle_reg;
    logic signed [31:0] heading_speed_reg;
    logic [47:0]        terrain_row0_reg;
    logic [47:0]        terrain_row1_reg;
    logic [47:0]        terrain_row2_reg;
    logic [WW-1:0]      rate_w_reg;
    logic [WW-1:0]      rate_w_next;
    logic [DW-1:0]      len_w_reg;
    logic [DW-1:0]      len_w_next;
    logic [DW-1:0]      hgt_w_reg;
    logic [DW-1:0]      hgt_w_next;
    logic [51:0]        wprod;
    logic [LPW-1:0]     lprod;
    logic [LPW-1:0]     hprod;
    cfg_reg_t           idx;

    assign cfg_ready = 1'b1;
    assign idx       = cfg_reg_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_length_reg   <= '0;
            step_height_reg   <= '0;
            swing_rate_reg    <= '0;
            heading_angle_reg <= '0;
            heading_speed_reg <= '0;
            terrain_row0_reg  <= '0;
            terrain_row1_reg  <= '0;
            terrain_row2_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (idx)
                REG_STEP_LENGTH:   step_length_reg   <= cfg_data[17:0];
                REG_STEP_HEIGHT:   step_height_reg   <= cfg_data[17:0];
                REG_SWING_RATE:    swing_rate_reg    <= cfg_data[19:0];
                REG_HEADING_ANGLE: heading_angle_reg <= cfg_data[15:0];
                REG_HEADING_SPEED: heading_speed_reg <= cfg_data[31:0];
                REG_TERRAIN_ROW0:  terrain_row0_reg  <= cfg_data;
                REG_TERRAIN_ROW1:  terrain_row1_reg  <= cfg_data;
                REG_TERRAIN_ROW2:  terrain_row2_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // pi*f, registered, then times length and height, registered again
    assign wprod       = 52'(PI_Q29) * 52'(swing_rate_reg);
    assign rate_w_next = WW'((wprod + (52'd1 << 28)) >> 29);
    assign lprod       = LPW'(rate_w_reg) * LPW'(step_length_reg);
    assign hprod       = LPW'(rate_w_reg) * LPW'(step_height_reg);
    assign len_w_next  = DW'((lprod + (LPW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
    assign hgt_w_next  = DW'((hprod + (LPW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_w_reg <= '0;
            len_w_reg  <= '0;
            hgt_w_reg  <= '0;
        end
        else
        begin
            rate_w_reg <= rate_w_next;
            len_w_reg  <= len_w_next;
            hgt_w_reg  <= hgt_w_next;
        end
    end

    always_comb
    begin
        cfg.step_length   = step_length_reg;
        cfg.step_height   = step_height_reg;
        cfg.swing_rate    = swing_rate_reg;
        cfg.heading_angle = heading_angle_reg;
        cfg.heading_speed = heading_speed_reg;
        cfg.terrain_row0  = terrain_row0_reg;
        cfg.terrain_row1  = terrain_row1_reg;
        cfg.terrain_row2  = terrain_row2_reg;
        cfg.len_w         = len_w_reg;
        cfg.hgt_w         = hgt_w_reg;
    end

endmodule

@@ sv/ftg_cordic.sv @@
// pipelined rotation-mode cordic, one stage per iteration
module ftg_cordic
    import ftg_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [31:0]          angle,
    output logic signed [TW-1:0] cos_val,
    output logic signed [TW-1:0] sin_val
);

    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1 <<< 30);
    localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd1 <<< 31);

    logic signed [CW-1:0] x_reg   [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg   [0:CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg   [0:CORDIC_STAGES];
    logic                 neg_reg [0:CORDIC_STAGES];
    logic signed [TW-1:0] cos_reg;
    logic signed [TW-1:0] sin_reg;
    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] z_fold;
    logic                 neg_fold;

    assign z_in = ZW'(signed'(angle));

    // fold into the right half plane; a folded angle negates both results
    always_comb
    begin
        z_fold   = z_in;
        neg_fold = 1'b0;
        if (z_in > QUARTER)
        begin
            z_fold   = z_in - HALF;
            neg_fold = 1'b1;
        end
        else if (z_in < -QUARTER)
        begin
            z_fold   = z_in + HALF;
            neg_fold = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CW'(X_INIT);
            y_reg[0]   <= '0;
            z_reg[0]   <= z_fold;
            neg_reg[0] <= neg_fold;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_TAB[i]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[CORDIC_STAGES] ? TW'(-x_reg[CORDIC_STAGES])
                                              : TW'(x_reg[CORDIC_STAGES]);
            sin_reg <= neg_reg[CORDIC_STAGES] ? TW'(-y_reg[CORDIC_STAGES])
                                              : TW'(y_reg[CORDIC_STAGES]);
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

@@ sv/ftg_rotate.sv @@
// offset, velocity, yaw and terrain rotation stages with saturating output register
module ftg_rotate
    import ftg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  cfg_t                 cfg,
    input  logic                 valid_in,
    input  logic signed [TW-1:0] cp,
    input  logic signed [TW-1:0] sp,
    input  logic signed [TW-1:0] ch,
    input  logic signed [TW-1:0] sh,
    input  logic signed [31:0]   st_x,
    input  logic signed [31:0]   st_y,
    input  logic signed [31:0]   st_z,
    output logic                 valid_out,
    output logic signed [31:0]   foot_x,
    output logic signed [31:0]   foot_y,
    output logic signed [31:0]   foot_z,
    output logic signed [31:0]   speed_x,
    output logic signed [31:0]   speed_y,
    output logic signed [31:0]   speed_z
);

    logic [4:0] vld_reg;

    logic signed [31:0]   st_reg [1:4][0:2];
    logic signed [TW-1:0] ch_reg;
    logic signed [TW-1:0] sh_reg;

    // stage 1
    logic signed [PW-1:0] xo_reg, zo_reg, xo_next, zo_next;
    logic signed [DW-1:0] xd_reg, zd_reg, xd_next, zd_next;
    // stage 2
    logic signed [PW-1:0] p2_reg [0:2];
    logic signed [PW-1:0] p2_next [0:2];
    logic signed [DW-1:0] a0_reg, a1_reg, a0_next, a1_next, v2_reg;
    // stage 3
    logic signed [PW-1:0] p3_reg [0:2];
    logic signed [VW-1:0] v3_reg [0:2];
    logic signed [VW-1:0] v3_next [0:2];
    // stage 4
    logic signed [EPW-1:0] mp_reg [0:2][0:2];
    logic signed [EVW-1:0] mv_reg [0:2][0:2];
    logic signed [EPW-1:0] mp_next [0:2][0:2];
    logic signed [EVW-1:0] mv_next [0:2][0:2];
    // stage 5
    logic signed [31:0] pos_next [0:2];
    logic signed [31:0] spd_next [0:2];
    logic signed [31:0] pos_reg [0:2];
    logic signed [31:0] spd_reg [0:2];

    logic signed [63:0] one64, l64, h64, lw64, hw64, r64;

    assign one64 = 64'sd1 <<< FRAC_BITS;
    assign l64   = 64'(cfg.step_length);
    assign h64   = 64'(cfg.step_height);
    assign lw64  = 64'(cfg.len_w);
    assign hw64  = 64'(cfg.hgt_w);
    assign r64   = 64'(cfg.heading_speed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], valid_in};
    end

    // half-ellipse offset and its derivative
    always_comb
    begin
        xo_next = PW'(rnd(l64 * (one64 - 64'(cp)), FRAC_BITS + 1));
        zo_next = PW'(rnd(h64 * 64'(sp), FRAC_BITS));
        xd_next = DW'(rnd(lw64 * 64'(sp), FRAC_BITS + 1));
        zd_next = DW'(rnd(hw64 * 64'(cp), FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xo_reg <= xo_next;
            zo_reg <= zo_next;
            xd_reg <= xd_next;
            zd_reg <= zd_next;
            ch_reg <= ch;
            sh_reg <= sh;
            st_reg[1][0] <= st_x;
            st_reg[1][1] <= st_y;
            st_reg[1][2] <= st_z;
        end
    end

    // heading yaw
    always_comb
    begin
        p2_next[0] = PW'(rnd(64'(ch_reg) * 64'(xo_reg), FRAC_BITS));
        p2_next[1] = PW'(rnd(64'(sh_reg) * 64'(xo_reg), FRAC_BITS));
        p2_next[2] = zo_reg;
        a0_next    = DW'(rnd(64'(ch_reg) * 64'(xd_reg), FRAC_BITS));
        a1_next    = DW'(rnd(64'(sh_reg) * 64'(xd_reg), FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg <= p2_next;
            a0_reg <= a0_next;
            a1_reg <= a1_next;
            v2_reg <= zd_reg;
            st_reg[2] <= st_reg[1];
        end
    end

    // yaw-rate cross term, skew entries (-r, +r)
    always_comb
    begin
        v3_next[0] = VW'(64'(a0_reg) - rnd(r64 * 64'(p2_reg[1]), FRAC_BITS));
        v3_next[1] = VW'(64'(a1_reg) + rnd(r64 * 64'(p2_reg[0]), FRAC_BITS));
        v3_next[2] = VW'(v2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_reg <= p2_reg;
            v3_reg <= v3_next;
            st_reg[3] <= st_reg[2];
        end
    end

    // transposed terrain products: output i uses column i of the matrix
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mp_next[i][0] = EPW'(64'(tentry(cfg.terrain_row0, i)) * 64'(p3_reg[0]));
            mp_next[i][1] = EPW'(64'(tentry(cfg.terrain_row1, i)) * 64'(p3_reg[1]));
            mp_next[i][2] = EPW'(64'(tentry(cfg.terrain_row2, i)) * 64'(p3_reg[2]));
            mv_next[i][0] = EVW'(64'(tentry(cfg.terrain_row0, i)) * 64'(v3_reg[0]));
            mv_next[i][1] = EVW'(64'(tentry(cfg.terrain_row1, i)) * 64'(v3_reg[1]));
            mv_next[i][2] = EVW'(64'(tentry(cfg.terrain_row2, i)) * 64'(v3_reg[2]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_reg <= mp_next;
            mv_reg <= mv_next;
            st_reg[4] <= st_reg[3];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_next[i] = sat32(64'(st_reg[4][i]) + rnd(64'(mp_reg[i][0]) + 64'(mp_reg[i][1])
                                + 64'(mp_reg[i][2]), TERRAIN_FRAC));
            spd_next[i] = sat32(rnd(64'(mv_reg[i][0]) + 64'(mv_reg[i][1])
                                + 64'(mv_reg[i][2]), TERRAIN_FRAC));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= pos_next;
            spd_reg <= spd_next;
        end
    end

    assign valid_out = vld_reg[4];
    assign foot_x    = pos_reg[0];
    assign foot_y    = pos_reg[1];
    assign foot_z    = pos_reg[2];
    assign speed_x   = spd_reg[0];
    assign speed_y   = spd_reg[1];
    assign speed_z   = spd_reg[2];

endmodule

@@ sv/ftg_checker.sv @@
// port-level checks for the foot swing trajectory core, bound to the top level
module ftg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [2:0]         cfg_index,
    input logic [47:0]        cfg_data,
    input logic               sample_valid,
    input logic               sample_stall,
    input logic [19:0]        sample_time,
    input logic signed [31:0] start_x,
    input logic signed [31:0] start_y,
    input logic signed [31:0] start_z,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [31:0] foot_x,
    input logic signed [31:0] foot_y,
    input logic signed [31:0] foot_z,
    input logic signed [31:0] speed_x,
    input logic signed [31:0] speed_y,
    input logic signed [31:0] speed_z
);

    // input side holds only when a result word is stuck
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("input stalled without a stalled result word");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> ($stable(foot_x) && $stable(foot_y)
            && $stable(foot_z) && $stable(speed_x) && $stable(speed_y)
            && $stable(speed_z)))
        else $error("stalled result word changed");

endmodule

bind foot_swing_trajectory_generator_core ftg_checker u_ftg_checker (.*);
